FILE: rtl/text_to_unsigned_parser_defines.svh
// ----------------------------------------------------------------------------
// Text-to-unsigned parser assertion macros
// Assertion wrappers shared by the parser RTL; empty when SYNTHESIS is set.
// ----------------------------------------------------------------------------
`ifndef TEXT_TO_UNSIGNED_PARSER_DEFINES_SVH
`define TEXT_TO_UNSIGNED_PARSER_DEFINES_SVH

`ifndef SYNTHESIS
// Property checked at every clock edge, also during reset.
`define TTUP_ASSERT_CLK(label, clk, prop) \
	label: assert property (@(posedge clk) (prop)) \
	else $error("text_to_unsigned_parser: check failed");
// Property checked only while reset is released.
`define TTUP_ASSERT_RST(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
	else $error("text_to_unsigned_parser: check failed");
`else
`define TTUP_ASSERT_CLK(label, clk, prop)
`define TTUP_ASSERT_RST(label, clk, rst_n, prop)
`endif

`endif

FILE: rtl/ttup_pkg.sv
// ----------------------------------------------------------------------------
// Text-to-unsigned parser package
// Parse phases, state and result types, character codes and digit helpers.
// ----------------------------------------------------------------------------
package ttup_pkg;

	localparam int unsigned VALUE_W  = 32;
	localparam int unsigned OFFSET_W = 16;
	localparam int unsigned BASE_W   = 5;

	localparam logic [VALUE_W-1:0] ALL_ONES = 32'hFFFF_FFFF;

	// Configuration register indexes.
	localparam logic REG_NUMBER_BASE = 1'b0;

	// Radix codes.
	localparam logic [BASE_W-1:0] BASE_AUTO    = 5'd0;
	localparam logic [BASE_W-1:0] BASE_INVALID = 5'd1;
	localparam logic [BASE_W-1:0] BASE_BIN     = 5'd2;
	localparam logic [BASE_W-1:0] BASE_DEC     = 5'd10;
	localparam logic [BASE_W-1:0] BASE_HEX     = 5'd16;

	// Character codes.
	localparam logic [7:0] CHAR_SPACE  = 8'h20;
	localparam logic [7:0] CHAR_TAB    = 8'h09;
	localparam logic [7:0] CHAR_CR     = 8'h0D;
	localparam logic [7:0] CHAR_PLUS   = 8'h2B;
	localparam logic [7:0] CHAR_ZERO   = 8'h30;
	localparam logic [7:0] CHAR_NINE   = 8'h39;
	localparam logic [7:0] CHAR_A_LOW  = 8'h61;
	localparam logic [7:0] CHAR_F_LOW  = 8'h66;
	localparam logic [7:0] CHAR_B_LOW  = 8'h62;
	localparam logic [7:0] CHAR_X_LOW  = 8'h78;
	localparam logic [7:0] CASE_BIT    = 8'h20;

	typedef enum logic [2:0] {
		PH_IDLE,
		PH_SPACE,
		PH_SIGNED,
		PH_ZERO,
		PH_PREFIX,
		PH_DIGITS
	} phase_t;

	typedef struct packed {
		phase_t              phase;
		logic [VALUE_W-1:0]  acc;
		logic                ovf;
		logic                any;
		logic [BASE_W-1:0]   eb;
		logic                pbin;
	} parse_state_t;

	typedef struct packed {
		logic [VALUE_W-1:0]  value;
		logic [OFFSET_W-1:0] offset;
		logic                found;
	} result_t;

	typedef struct packed {
		logic       valid;
		logic [3:0] value;
	} digit_t;

	// Decode one character as a digit of radix up to 16.
	function automatic digit_t digit_of(input logic [7:0] c);
		digit_t     d;
		logic [7:0] low;
		d.valid = 1'b0;
		d.value = 4'd0;
		low = c | CASE_BIT;
		if (c >= CHAR_ZERO && c <= CHAR_NINE) begin
			d.valid = 1'b1;
			d.value = 4'(c - CHAR_ZERO);
		end else if (low >= CHAR_A_LOW && low <= CHAR_F_LOW) begin
			d.valid = 1'b1;
			d.value = 4'(low - CHAR_A_LOW + 8'd10);
		end
		return d;
	endfunction

	// Space, tab, newline, vertical tab, form feed or carriage return.
	function automatic logic is_space(input logic [7:0] c);
		return (c == CHAR_SPACE) || (c >= CHAR_TAB && c <= CHAR_CR);
	endfunction

endpackage

FILE: rtl/ttup_step.sv
// ----------------------------------------------------------------------------
// Text-to-unsigned parser step
// Next-state and result logic for one byte: phase decode and multiply-add.
// ----------------------------------------------------------------------------
module ttup_step #(
	parameter int unsigned POSITION_BITS = 16
) (
	input  ttup_pkg::parse_state_t    cur,
	input  logic [POSITION_BITS-1:0]  cur_pos,
	input  logic [7:0]                text_byte,
	input  logic                      string_start,
	input  logic [ttup_pkg::BASE_W-1:0] number_base,
	output ttup_pkg::parse_state_t    nxt,
	output logic [POSITION_BITS-1:0]  nxt_pos,
	output logic                      emit,
	output ttup_pkg::result_t         res
);

	ttup_pkg::parse_state_t       st;
	logic [POSITION_BITS-1:0]     pos;
	logic [POSITION_BITS:0]       sum1;
	logic [POSITION_BITS:0]       sum2;
	logic [POSITION_BITS-1:0]     pos1;
	logic [POSITION_BITS-1:0]     pos2;
	logic [POSITION_BITS+15:0]    pos_ext;
	logic [ttup_pkg::OFFSET_W-1:0] pos_offset;
	ttup_pkg::digit_t             dig;
	logic [ttup_pkg::BASE_W-1:0]  db;
	logic [ttup_pkg::BASE_W-1:0]  limit;
	logic [36:0]                  prod;
	logic [36:0]                  mac;
	logic                         base_bad;
	logic                         lead;
	logic                         digit_path;
	logic                         lead_zero;

	// Start byte clears the string state before the byte is decoded.
	always_comb begin
		st  = cur;
		pos = cur_pos;
		if (string_start) begin
			st.acc   = '0;
			st.ovf   = 1'b0;
			st.any   = 1'b0;
			st.pbin  = 1'b0;
			st.eb    = number_base;
			st.phase = ttup_pkg::PH_SPACE;
			pos      = '0;
		end
	end

	// Saturating position increments by one and by two.
	assign sum1 = {1'b0, pos} + {{POSITION_BITS{1'b0}}, 1'b1};
	assign sum2 = {1'b0, pos} + {{(POSITION_BITS-1){1'b0}}, 2'd2};
	assign pos1 = sum1[POSITION_BITS] ? '1 : sum1[POSITION_BITS-1:0];
	assign pos2 = sum2[POSITION_BITS] ? '1 : sum2[POSITION_BITS-1:0];

	// The offset port keeps the low bits of the position.
	assign pos_ext    = {16'b0, pos};
	assign pos_offset = pos_ext[ttup_pkg::OFFSET_W-1:0];

	// Digit decode and the single multiply-add; overflow when any bit above bit 31 is set.
	assign dig   = ttup_pkg::digit_of(text_byte);
	assign db    = (st.eb == ttup_pkg::BASE_AUTO) ? ttup_pkg::BASE_DEC : st.eb;
	assign limit = st.pbin ? ttup_pkg::BASE_BIN : ttup_pkg::BASE_HEX;
	assign prod  = 37'(st.acc) * 37'(db);
	assign mac   = prod + 37'(dig.value);

	assign base_bad  = (number_base == ttup_pkg::BASE_INVALID) ||
	                   (number_base > ttup_pkg::BASE_HEX);
	assign lead_zero = (text_byte == ttup_pkg::CHAR_ZERO) &&
	                   ((st.eb == ttup_pkg::BASE_AUTO) || (st.eb == ttup_pkg::BASE_HEX));

	// Phase decode.
	always_comb begin
		nxt        = st;
		nxt_pos    = pos;
		emit       = 1'b0;
		res.value  = '0;
		res.offset = '0;
		res.found  = 1'b0;
		lead       = 1'b0;
		digit_path = 1'b0;

		if (string_start && base_bad) begin
			emit      = 1'b1;
			nxt.phase = ttup_pkg::PH_IDLE;
		end else begin
			case (st.phase)
				ttup_pkg::PH_SPACE: begin
					if (ttup_pkg::is_space(text_byte)) begin
						nxt_pos = pos1;
					end else if (text_byte == ttup_pkg::CHAR_PLUS) begin
						nxt_pos   = pos1;
						nxt.phase = ttup_pkg::PH_SIGNED;
					end else begin
						lead = 1'b1;
					end
				end
				ttup_pkg::PH_SIGNED: begin
					lead = 1'b1;
				end
				ttup_pkg::PH_ZERO: begin
					if ((text_byte | ttup_pkg::CASE_BIT) == ttup_pkg::CHAR_X_LOW) begin
						nxt.pbin  = 1'b0;
						nxt.phase = ttup_pkg::PH_PREFIX;
					end else if ((text_byte | ttup_pkg::CASE_BIT) == ttup_pkg::CHAR_B_LOW &&
					             st.eb == ttup_pkg::BASE_DEC) begin
						nxt.pbin  = 1'b1;
						nxt.phase = ttup_pkg::PH_PREFIX;
					end else begin
						digit_path = 1'b1;
					end
				end
				ttup_pkg::PH_PREFIX: begin
					if (dig.valid && ({1'b0, dig.value} < limit)) begin
						nxt.eb    = limit;
						nxt.acc   = 32'(dig.value);
						nxt_pos   = pos2;
						nxt.phase = ttup_pkg::PH_DIGITS;
					end else begin
						// Prefix with no digit after it ends at the prefix letter.
						emit       = 1'b1;
						res.offset = pos_offset;
						res.found  = 1'b1;
						nxt.phase  = ttup_pkg::PH_IDLE;
					end
				end
				ttup_pkg::PH_DIGITS: begin
					digit_path = 1'b1;
				end
				default: begin
				end
			endcase

			// First significant byte: a leading zero may open a prefix.
			if (lead) begin
				if (lead_zero) begin
					nxt.eb    = (st.eb == ttup_pkg::BASE_AUTO) ? ttup_pkg::BASE_DEC :
					            ttup_pkg::BASE_HEX;
					nxt.acc   = '0;
					nxt.any   = 1'b1;
					nxt_pos   = pos1;
					nxt.phase = ttup_pkg::PH_ZERO;
				end else begin
					digit_path = 1'b1;
				end
			end

			// Digit accumulation, or the stop byte that emits the result.
			if (digit_path) begin
				nxt.eb    = db;
				nxt.phase = ttup_pkg::PH_DIGITS;
				if (dig.valid && ({1'b0, dig.value} < db)) begin
					nxt.acc = mac[31:0];
					nxt.ovf = st.ovf | (|mac[36:32]);
					nxt.any = 1'b1;
					nxt_pos = pos1;
				end else begin
					emit       = 1'b1;
					res.value  = st.ovf ? ttup_pkg::ALL_ONES : st.acc;
					res.offset = st.any ? pos_offset : '0;
					res.found  = st.any;
					nxt.phase  = ttup_pkg::PH_IDLE;
				end
			end
		end
	end

endmodule

FILE: rtl/text_to_unsigned_parser.sv
// ----------------------------------------------------------------------------
// Text-to-unsigned parser
// Saturating string-to-unsigned conversion in bases 2 to 16, one byte a beat.
// ----------------------------------------------------------------------------
// The parser takes one text byte every clock cycle, with no gaps, as long as the
// result side keeps up. A byte is captured in an input register and decoded in
// the next cycle by one short multiply-add step (32 by 5 bits) that updates the
// parse state; the result of a stop byte is loaded into the output register as
// the byte leaves the input register, and waits there while result_stall is
// high. The input stalls only while a finished result waits in the output
// register and the byte in the input register would produce another.
// The radix register is sampled with each start byte, so the user must write it
// only between strings; the block does not enforce this.
`include "text_to_unsigned_parser_defines.svh"

module text_to_unsigned_parser #(
	parameter int unsigned POSITION_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,

	input  logic        text_valid,
	output logic        text_stall,
	input  logic [7:0]  text_byte,
	input  logic        string_start,

	output logic        result_valid,
	input  logic        result_stall,
	output logic [31:0] parsed_value,
	output logic [15:0] end_offset,
	output logic        digits_found,

	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	logic [ttup_pkg::BASE_W-1:0] number_base_q;
	logic                        valid_s1;
	logic [7:0]                  byte_s1;
	logic                        start_s1;
	ttup_pkg::parse_state_t      state_q;
	logic [POSITION_BITS-1:0]    pos_q;
	ttup_pkg::parse_state_t      state_nxt;
	logic [POSITION_BITS-1:0]    pos_nxt;
	logic                        step_emit;
	ttup_pkg::result_t           step_res;
	logic                        out_free;
	logic                        advance;

	// Configuration port: single radix register at word 0.
	assign pready = 1'b1;
	assign prdata = (paddr[2] == ttup_pkg::REG_NUMBER_BASE) ?
	                {27'b0, number_base_q} : 32'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			number_base_q <= '0;
		end else if (psel && penable && pwrite && pready &&
		             paddr[2] == ttup_pkg::REG_NUMBER_BASE) begin
			number_base_q <= pwdata[ttup_pkg::BASE_W-1:0];
		end
	end

	// Byte decode for the beat in the input register.
	ttup_step #(
		.POSITION_BITS(POSITION_BITS)
	) u_step (
		.cur          (state_q),
		.cur_pos      (pos_q),
		.text_byte    (byte_s1),
		.string_start (start_s1),
		.number_base  (number_base_q),
		.nxt          (state_nxt),
		.nxt_pos      (pos_nxt),
		.emit         (step_emit),
		.res          (step_res)
	);

	// Flow control: the input beat moves on unless its result has nowhere to go.
	assign out_free   = !result_valid || !result_stall;
	assign advance    = valid_s1 && (!step_emit || out_free);
	assign text_stall = valid_s1 && !advance;

	// Input register valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!text_stall) begin
			valid_s1 <= text_valid;
		end
	end

	// Input register payload.
	always_ff @(posedge clk) begin
		if (text_valid && !text_stall) begin
			byte_s1  <= text_byte;
			start_s1 <= string_start;
		end
	end

	// Parse state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.phase <= ttup_pkg::PH_IDLE;
			state_q.acc   <= '0;
			state_q.ovf   <= 1'b0;
			state_q.any   <= 1'b0;
			state_q.eb    <= '0;
			state_q.pbin  <= 1'b0;
			pos_q         <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
			pos_q   <= pos_nxt;
		end
	end

	// Result register valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance && step_emit) begin
			result_valid <= 1'b1;
		end else if (!result_stall) begin
			result_valid <= 1'b0;
		end
	end

	// Result register payload.
	always_ff @(posedge clk) begin
		if (advance && step_emit) begin
			parsed_value <= step_res.value;
			end_offset   <= step_res.offset;
			digits_found <= step_res.found;
		end
	end

	// Checks.
	`TTUP_ASSERT_CLK(a_stall_only_on_full_output, clk,
		text_stall |-> (result_valid && result_stall && step_emit))
	`TTUP_ASSERT_RST(a_idle_after_result, clk, arst_n,
		(advance && step_emit) |=> (state_q.phase == ttup_pkg::PH_IDLE))
	`TTUP_ASSERT_RST(a_no_digits_gives_zero, clk, arst_n,
		(result_valid && !digits_found) |-> (parsed_value == 32'd0 && end_offset == 16'd0))

endmodule
